>>> hw/rtl/tcc_pkg.sv
// Shared types and constants for the text console cursor.
package tcc_pkg;

    localparam int unsigned TAB_STOP_DEF = 8;
    localparam int unsigned MAX_FILL     = 8;   // fill cells emitted per tab, at most
    localparam int unsigned SIZE_W       = 6;   // width of the size registers
    localparam int unsigned POS_W        = 5;   // width of a column or row
    localparam int unsigned CODE_W       = 8;
    localparam int unsigned CNT_W        = 4;   // holds 0..MAX_FILL

    localparam logic [SIZE_W-1:0] LINE_WIDTH_RST = 6'd28;
    localparam logic [SIZE_W-1:0] LINE_COUNT_RST = 6'd18;
    localparam logic [SIZE_W-1:0] SIZE_MAX       = 6'd32;

    localparam logic [CODE_W-1:0] CH_NUL   = 8'd0;
    localparam logic [CODE_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CODE_W-1:0] CH_NL    = 8'd10;
    localparam logic [CODE_W-1:0] CH_SPACE = 8'd32;

    // register indexes on the configuration port
    localparam logic CFG_LINE_WIDTH = 1'b0;
    localparam logic CFG_LINE_COUNT = 1'b1;

    // input op codes
    localparam logic OP_PUT   = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_NL,
        S_PUT,
        S_CLEAR,
        S_TAB_SETUP,
        S_TAB_EMIT
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_LATCH,
        DP_NORM,
        DP_NEWLINE,
        DP_PUT,
        DP_CLEAR,
        DP_TAB_SETUP,
        DP_TAB_EMIT
    } t_dp_cmd;

    typedef struct packed {
        logic op_clear;
        logic ch_nul;
        logic ch_nl;
        logic ch_tab;
        logic tab_final;
        logic out_free;
    } t_dp_status;

endpackage

>>> hw/rtl/tcc_ctrl.sv
// Sequencer for the text console cursor: item handshake and datapath commands.
module tcc_ctrl
    import tcc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = DP_NOP;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall = !i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd   = DP_LATCH;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.op_clear) begin
                    n_state = S_CLEAR;
                end else if (i_status.ch_nul) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd = DP_NORM;
                    if (i_status.ch_nl) begin
                        n_state = S_NL;
                    end else if (i_status.ch_tab) begin
                        n_state = S_TAB_SETUP;
                    end else begin
                        n_state = S_PUT;
                    end
                end
            end
            S_NL: begin
                o_cmd   = DP_NEWLINE;
                n_state = S_IDLE;
            end
            S_PUT: begin
                if (i_status.out_free) begin
                    o_cmd   = DP_PUT;
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (i_status.out_free) begin
                    o_cmd   = DP_CLEAR;
                    n_state = S_IDLE;
                end
            end
            S_TAB_SETUP: begin
                o_cmd   = DP_TAB_SETUP;
                n_state = S_TAB_EMIT;
            end
            S_TAB_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd = DP_TAB_EMIT;
                    if (i_status.tab_final) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    // a waiting word is never overwritten by a new cell write
    a_no_load_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd == DP_PUT || o_cmd == DP_CLEAR || o_cmd == DP_TAB_EMIT) |-> i_status.out_free)
        else $error("cell write issued while output word still held");
    // a printable character finishes as soon as its cell is taken
    a_put_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUT && i_status.out_free) |=> r_state == S_IDLE)
        else $error("put did not return to idle");
`endif

endmodule

>>> hw/rtl/tcc_dp.sv
// Datapath for the text console cursor: cursor, sizes, tab fill and output word.
module tcc_dp
    import tcc_pkg::*;
#(
    parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_op,
    input  logic [CODE_W-1:0] i_ch,
    input  t_dp_cmd           i_cmd,
    output t_dp_status        o_status,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_col,
    output logic [POS_W-1:0]  o_row,
    output logic [CODE_W-1:0] o_code,
    output logic              o_clear_screen,
    output logic              o_last
);

    localparam int unsigned PH_W = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
    localparam logic [PH_W-1:0]   PH_LAST  = PH_W'(TAB_STOP - 1);
    localparam logic [SIZE_W-1:0] STOP_LEN = SIZE_W'(TAB_STOP);
    localparam logic [SIZE_W-1:0] FILL_CAP = SIZE_W'(MAX_FILL);

    function automatic logic [SIZE_W-1:0] f_clamp(input logic [SIZE_W-1:0] v);
        logic [SIZE_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > SIZE_MAX) begin
            res = SIZE_MAX;
        end
        return res;
    endfunction

    function automatic logic [POS_W-1:0] f_row_adv(input logic [POS_W-1:0] row,
                                                   input logic [SIZE_W-1:0] h);
        logic [SIZE_W-1:0] nxt;
        nxt = SIZE_W'(row) + SIZE_W'(1);
        return (nxt >= h) ? '0 : nxt[POS_W-1:0];
    endfunction

    logic              r_op;
    logic [CODE_W-1:0] r_ch;
    logic [SIZE_W-1:0] r_line_w;
    logic [SIZE_W-1:0] r_line_h;
    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_row;
    logic [PH_W-1:0]   r_phase;     // r_col modulo the tab stop
    logic [POS_W-1:0]  r_tab_col;
    logic [CNT_W-1:0]  r_tab_cnt;
    logic [SIZE_W-1:0] r_tab_len;
    logic              r_tab_wrap;
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_col;
    logic [POS_W-1:0]  r_out_row;
    logic [CODE_W-1:0] r_out_code;
    logic              r_out_clear;
    logic              r_out_last;

    logic              out_free;
    logic [POS_W-1:0]  norm_row;
    logic [SIZE_W-1:0] col_inc;
    logic [SIZE_W-1:0] tab_len;
    logic              tab_wrap;
    logic [SIZE_W-1:0] tab_fill;
    logic [PH_W-1:0]   phase_inc;

    assign out_free  = !r_out_valid || !i_out_stall;
    assign norm_row  = (SIZE_W'(r_row) >= r_line_h) ? '0 : r_row;
    assign col_inc   = SIZE_W'(r_col) + SIZE_W'(1);
    assign phase_inc = (r_phase == PH_LAST) ? '0 : r_phase + PH_W'(1);
    assign tab_len   = STOP_LEN - SIZE_W'(r_phase);
    assign tab_wrap  = (SIZE_W'(r_col) + tab_len) >= r_line_w;
    assign tab_fill  = tab_wrap ? (r_line_w - SIZE_W'(r_col)) : tab_len;

    assign o_status.op_clear  = (r_op == OP_CLEAR);
    assign o_status.ch_nul    = (r_ch == CH_NUL);
    assign o_status.ch_nl     = (r_ch == CH_NL);
    assign o_status.ch_tab    = (r_ch == CH_TAB);
    assign o_status.tab_final = (r_tab_cnt == CNT_W'(1));
    assign o_status.out_free  = out_free;

    // configuration and cursor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_w  <= LINE_WIDTH_RST;
            r_line_h  <= LINE_COUNT_RST;
            r_col     <= '0;
            r_row     <= '0;
            r_phase   <= '0;
            r_tab_cnt <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_LINE_WIDTH: r_line_w <= f_clamp(i_cfg_data);
                    CFG_LINE_COUNT: r_line_h <= f_clamp(i_cfg_data);
                    default: ;
                endcase
            end
            case (i_cmd)
                DP_NORM: begin
                    if (SIZE_W'(r_col) >= r_line_w) begin
                        r_col   <= '0;
                        r_phase <= '0;
                        r_row   <= f_row_adv(norm_row, r_line_h);
                    end else begin
                        r_row <= norm_row;
                    end
                end
                DP_NEWLINE: begin
                    r_col   <= '0;
                    r_phase <= '0;
                    r_row   <= f_row_adv(r_row, r_line_h);
                end
                DP_PUT: begin
                    if (col_inc >= r_line_w) begin
                        r_col   <= '0;
                        r_phase <= '0;
                        r_row   <= f_row_adv(r_row, r_line_h);
                    end else begin
                        r_col   <= col_inc[POS_W-1:0];
                        r_phase <= phase_inc;
                    end
                end
                DP_CLEAR: begin
                    r_col   <= '0;
                    r_row   <= '0;
                    r_phase <= '0;
                end
                DP_TAB_SETUP: begin
                    r_tab_cnt <= (tab_fill > FILL_CAP) ? CNT_W'(MAX_FILL)
                                                       : tab_fill[CNT_W-1:0];
                end
                DP_TAB_EMIT: begin
                    r_tab_cnt <= r_tab_cnt - CNT_W'(1);
                    if (r_tab_cnt == CNT_W'(1)) begin
                        r_phase <= '0;
                        if (r_tab_wrap) begin
                            r_col <= '0;
                            r_row <= f_row_adv(r_row, r_line_h);
                        end else begin
                            r_col <= POS_W'(SIZE_W'(r_col) + r_tab_len);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // item and tab payload
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_LATCH: begin
                r_op <= i_op;
                r_ch <= i_ch;
            end
            DP_TAB_SETUP: begin
                r_tab_col  <= r_col;
                r_tab_len  <= tab_len;
                r_tab_wrap <= tab_wrap;
            end
            DP_TAB_EMIT: begin
                r_tab_col <= r_tab_col + POS_W'(1);
            end
            default: ;
        endcase
    end

    // output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == DP_PUT || i_cmd == DP_CLEAR || i_cmd == DP_TAB_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            DP_PUT: begin
                r_out_col   <= r_col;
                r_out_row   <= r_row;
                r_out_code  <= r_ch;
                r_out_clear <= 1'b0;
                r_out_last  <= 1'b1;
            end
            DP_CLEAR: begin
                r_out_col   <= '0;
                r_out_row   <= '0;
                r_out_code  <= '0;
                r_out_clear <= 1'b1;
                r_out_last  <= 1'b1;
            end
            DP_TAB_EMIT: begin
                r_out_col   <= r_tab_col;
                r_out_row   <= r_row;
                r_out_code  <= CH_SPACE;
                r_out_clear <= 1'b0;
                r_out_last  <= (r_tab_cnt == CNT_W'(1));
            end
            default: ;
        endcase
    end

    assign o_out_valid    = r_out_valid;
    assign o_col          = r_out_col;
    assign o_row          = r_out_row;
    assign o_code         = r_out_code;
    assign o_clear_screen = r_out_clear;
    assign o_last         = r_out_last;

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_phase) < TAB_STOP)
        else $error("tab phase out of range");
    a_tab_cnt_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_TAB_EMIT) |-> (r_tab_cnt != '0 && 32'(r_tab_cnt) <= MAX_FILL))
        else $error("tab fill emitted with bad count");
    a_clear_homes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd == DP_CLEAR) |=> (r_col == '0 && r_row == '0 && r_out_clear && r_out_valid))
        else $error("clear did not home cursor");
`endif

endmodule

>>> hw/rtl/text_console_cursor.sv
// Top level of the text console cursor: sequencer plus datapath.
//
//  channel  | handshake               | word
//  ---------+-------------------------+--------------------------------------
//  cfg      | i_cfg_we                | i_cfg_index, i_cfg_data
//  in       | i_in_valid / o_in_stall | i_op, i_ch
//  out      | o_out_valid / i_out_stall | o_col, o_row, o_code,
//           |                         |   o_clear_screen, o_last
//
// One word in at a time. NUL ends at decode; newline, printable character or
// clear take decode and one more step; a tab takes decode, a setup step and
// one emit step per fill cell (up to 8). Cell writes wait for a free output
// register. Cost is set by the sequencer walking decode, cursor normalise and
// emit steps, and by the single output register (one cell a cycle, no stall).
// Reset is synchronous and active low: cursor homes, sizes return to 28 x 18.
// A stalled output word holds; the input stays stalled until the last cell
// of the current word is in the output register.
module text_console_cursor
    import tcc_pkg::*;
#(
    parameter int unsigned TAB_STOP = TAB_STOP_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [SIZE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic              i_op,
    input  logic [CODE_W-1:0] i_ch,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [POS_W-1:0]  o_col,
    output logic [POS_W-1:0]  o_row,
    output logic [CODE_W-1:0] o_code,
    output logic              o_clear_screen,
    output logic              o_last
);

    // command and status between sequencer and datapath
    t_dp_cmd    cmd;
    t_dp_status status;

    tcc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // cursor, sizes, tab fill counter and the output register
    tcc_dp #(
        .TAB_STOP (TAB_STOP)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_op           (i_op),
        .i_ch           (i_ch),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_col          (o_col),
        .o_row          (o_row),
        .o_code         (o_code),
        .o_clear_screen (o_clear_screen),
        .o_last         (o_last)
    );

endmodule

>>> tb/text_console_cursor_tb.sv
// Self-checking testbench for the text console cursor: directed and random words.
module text_console_cursor_tb
    import tcc_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Pause after the last cell write before the block can be called idle.
    // A NUL or newline word, which writes no cell, can still be in flight then.
    localparam int SETTLE_CYCLES = 12;
    localparam int HOLD_CYCLES   = 80;   // long receiver hold-off
    localparam int IDLE_PCT      = 13;
    localparam int TAB_PITCH     = TAB_STOP_DEF;
    localparam int PHASES        = 7;
    localparam int PHASE_WORDS   = 18;

    typedef struct packed {
        logic              op;
        logic [CODE_W-1:0] ch;
    } console_word_t;

    typedef struct packed {
        logic [POS_W-1:0]  col;
        logic [POS_W-1:0]  row;
        logic [CODE_W-1:0] code;
        logic              clr;
        logic              last;
    } cell_write_t;

    // ---------------------------------------------------------------- signals
    logic              i_clk          = 1'b0;
    logic              i_rst_n        = 1'b0;
    logic              cfg_we         = 1'b0;
    logic              cfg_index      = CFG_LINE_WIDTH;
    logic [SIZE_W-1:0] cfg_data       = '0;
    logic              in_valid       = 1'b0;
    logic              in_op          = OP_PUT;
    logic [CODE_W-1:0] in_ch          = CH_NUL;
    logic              out_stall      = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [POS_W-1:0]  o_col;
    logic [POS_W-1:0]  o_row;
    logic [CODE_W-1:0] o_code;
    logic              o_clear_screen;
    logic              o_last;

    // ---------------------------------------------------------- tb bookkeeping
    console_word_t pending_words[$];   // words still to be offered
    cell_write_t   expected_cells[$];  // cell writes the block owes us
    console_word_t next_word;
    cell_write_t   due_cell;

    // predicted console state, mirrors the block's registers
    logic [SIZE_W-1:0] width_reg = LINE_WIDTH_RST;
    logic [SIZE_W-1:0] count_reg = LINE_COUNT_RST;
    int cur_col = 0;
    int cur_row = 0;

    int mismatches     = 0;
    int words_taken    = 0;
    int tab_words      = 0;
    int cells_checked  = 0;
    int clears_checked = 0;
    int geometries     = 0;

    // idling control
    bit quiet_run   = 1'b0;   // no idling on either side while set
    int hold_reqs   = 0;      // bumped by the stimulus to ask for a hold-off
    int hold_served = 0;
    int hold_left   = 0;

    text_console_cursor dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (o_in_stall),
        .i_op          (in_op),
        .i_ch          (in_ch),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (out_stall),
        .o_col         (o_col),
        .o_row         (o_row),
        .o_code        (o_code),
        .o_clear_screen(o_clear_screen),
        .o_last        (o_last)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs or owes cells it never sends.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // -------------------------------------------------------------- predictor
    // Out-of-range sizes: 0 behaves as 1, anything above 32 as 32.
    function automatic int clamp_size(logic [SIZE_W-1:0] v);
        if (v == '0) return 1;
        if (v > SIZE_MAX) return int'(SIZE_MAX);
        return int'(v);
    endfunction

    function automatic void advance_line(int h);
        cur_col = 0;
        cur_row = cur_row + 1;
        if (cur_row >= h) cur_row = 0;
    endfunction

    function automatic void queue_cell(int c, int r, int code, bit clr, bit last);
        cell_write_t wr;
        wr.col  = c[POS_W-1:0];
        wr.row  = r[POS_W-1:0];
        wr.code = code[CODE_W-1:0];
        wr.clr  = clr;
        wr.last = last;
        expected_cells.push_back(wr);
    endfunction

    // Works out the cell writes one accepted word causes and moves the cursor.
    function automatic void predict_console(logic op, logic [CODE_W-1:0] ch);
        int w;
        int h;
        int span;
        int fill;
        bit wraps;
        w = clamp_size(width_reg);
        h = clamp_size(count_reg);
        if (op == OP_CLEAR) begin
            cur_col = 0;
            cur_row = 0;
            queue_cell(0, 0, 0, 1'b1, 1'b1);
            return;
        end
        if (ch == CH_NUL) return;
        // cursor may sit outside the area after the sizes shrank
        if (cur_row >= h) cur_row = 0;
        if (cur_col >= w) advance_line(h);
        if (ch == CH_NL) begin
            advance_line(h);
            return;
        end
        if (ch == CH_TAB) begin
            span  = TAB_PITCH - (cur_col % TAB_PITCH);
            wraps = (cur_col + span >= w);
            fill  = wraps ? (w - cur_col) : span;
            if (fill > int'(MAX_FILL)) fill = int'(MAX_FILL);
            for (int i = 0; i < fill; i++) begin
                queue_cell(cur_col + i, cur_row, CH_SPACE, 1'b0, i == fill - 1);
            end
            if (wraps) advance_line(h);
            else cur_col = cur_col + span;
            return;
        end
        queue_cell(cur_col, cur_row, ch, 1'b0, 1'b1);
        cur_col = cur_col + 1;
        if (cur_col >= w) advance_line(h);
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // ----------------------------------------------------------------- driver
    // Offers the next pending word; the prediction is taken on acceptance,
    // so it always sees the sizes the block sees.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                predict_console(in_op, in_ch);
                words_taken++;
                if (in_op == OP_PUT && in_ch == CH_TAB) tab_words++;
            end
            if (!in_valid || !o_in_stall) begin
                if (pending_words.size() != 0 &&
                    (quiet_run || $urandom_range(99) >= IDLE_PCT)) begin
                    next_word = pending_words.pop_front();
                    in_valid <= 1'b1;
                    in_op    <= next_word.op;
                    in_ch    <= next_word.ch;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // --------------------------------------------------------------- receiver
    // Random stalls, plus a long hold-off whenever the stimulus asks for one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_served != hold_reqs) begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_CYCLES;
            out_stall   <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (quiet_run) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(99) < IDLE_PCT);
        end
    end

    // ---------------------------------------------------------------- monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (expected_cells.size() == 0) begin
                report_mismatch($sformatf("unexpected word col=%0d row=%0d code=%0d clr=%0b",
                                          o_col, o_row, o_code, o_clear_screen));
            end else begin
                due_cell = expected_cells.pop_front();
                if (o_col !== due_cell.col)
                    report_mismatch($sformatf("col %0d, want %0d", o_col, due_cell.col));
                if (o_row !== due_cell.row)
                    report_mismatch($sformatf("row %0d, want %0d", o_row, due_cell.row));
                if (o_code !== due_cell.code)
                    report_mismatch($sformatf("code %0d, want %0d", o_code, due_cell.code));
                if (o_clear_screen !== due_cell.clr)
                    report_mismatch($sformatf("clear_screen %0b, want %0b",
                                              o_clear_screen, due_cell.clr));
                if (o_last !== due_cell.last)
                    report_mismatch($sformatf("last %0b, want %0b", o_last, due_cell.last));
                if (due_cell.clr) clears_checked++;
                else cells_checked++;
            end
        end
    end

    // --------------------------------------------------------------- stimulus
    task automatic queue_word(logic op, logic [CODE_W-1:0] ch);
        console_word_t wd;
        wd.op = op;
        wd.ch = ch;
        pending_words.push_back(wd);
    endtask

    // Sender holds back until every owed cell has arrived and the block
    // has had time to finish a trailing NUL or newline.
    task automatic await_idle();
        while (pending_words.size() != 0 || in_valid || expected_cells.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [SIZE_W-1:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_LINE_WIDTH) width_reg = val;
        else count_reg = val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_geometry(logic [SIZE_W-1:0] w, logic [SIZE_W-1:0] h);
        await_idle();
        write_reg(CFG_LINE_WIDTH, w);
        write_reg(CFG_LINE_COUNT, h);
        geometries++;
    endtask

    // Mix weighted towards text so lines fill and wrap; tabs, newlines,
    // NULs and clears sprinkled in. Full code range for plain characters.
    task automatic queue_random(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(99);
            if (pick < 5)       queue_word(OP_CLEAR, CODE_W'($urandom_range(255)));
            else if (pick < 10) queue_word(OP_PUT, CH_NUL);
            else if (pick < 22) queue_word(OP_PUT, CH_NL);
            else if (pick < 40) queue_word(OP_PUT, CH_TAB);
            else                queue_word(OP_PUT, CODE_W'($urandom_range(255)));
        end
    endtask

    int geo_w[PHASES] = '{32, 1, 0, 7, 13, 2, 63};
    int geo_h[PHASES] = '{32, 1, 63, 3, 5, 32, 0};

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // default 28 x 18: clear ignores ch, plain text, NUL, tabs inside a line
        queue_word(OP_CLEAR, 8'hFF);
        queue_word(OP_PUT, 8'h48);
        queue_word(OP_PUT, CH_NUL);
        queue_word(OP_PUT, CH_TAB);
        queue_word(OP_PUT, CH_TAB);
        queue_word(OP_PUT, 8'hFF);
        queue_word(OP_PUT, CH_NL);
        queue_word(OP_PUT, 8'h01);

        // 1 x 1: every character wraps, a tab fills a single cell
        set_geometry(6'd1, 6'd1);
        queue_word(OP_PUT, 8'h61);
        queue_word(OP_PUT, CH_TAB);
        queue_word(OP_PUT, CH_NL);
        queue_word(OP_PUT, CH_NUL);

        // out-of-range sizes: width 63 acts as 32, height 0 as 1;
        // fourth tab runs into the line end
        set_geometry(6'd63, 6'd0);
        repeat (4) queue_word(OP_PUT, CH_TAB);
        queue_word(OP_CLEAR, CH_NUL);

        // 32 x 32: park the cursor far out at row 2, column 24
        set_geometry(SIZE_MAX, SIZE_MAX);
        queue_word(OP_PUT, CH_NL);
        queue_word(OP_PUT, CH_NL);
        repeat (3) queue_word(OP_PUT, CH_TAB);

        // shrink under the cursor: row and column fall outside and get normalised
        set_geometry(6'd5, 6'd2);
        queue_word(OP_PUT, 8'h7A);
        queue_word(OP_PUT, CH_TAB);

        // random phases across geometries, extremes among them
        for (int p = 0; p < PHASES; p++) begin
            set_geometry(SIZE_W'(geo_w[p]), SIZE_W'(geo_h[p]));
            quiet_run = (p == 4);
            if (p == 2) hold_reqs++;   // block fills up and stalls its input
            queue_random(PHASE_WORDS);
        end

        await_idle();
        quiet_run = 1'b0;

        $display("covered %0d words (%0d tabs) over %0d geometries", words_taken,
                 tab_words, geometries + 1);
        $display("checked %0d cell writes and %0d screen clears", cells_checked,
                 clears_checked);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/tcc_pkg.sv
hw/rtl/tcc_ctrl.sv
hw/rtl/tcc_dp.sv
hw/rtl/text_console_cursor.sv
tb/text_console_cursor_tb.sv
